[hdl/asd_pkg.sv]
// shared types and constants for the accelerometer step detector
package asd_pkg;

  localparam int AXIS_W     = 16;
  localparam int TIME_W     = 32;
  localparam int MAG_W      = 16;
  localparam int SQ_W       = 32;
  localparam int ROOT_W     = 16;
  localparam int RECIP_W    = 13;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  // reciprocal of 9.8 in unsigned q0.16, rounded down
  localparam logic [RECIP_W-1:0] G_RECIP_Q16 = 13'd6687;

  localparam logic REQ_CLEAR = 1'b1;

  localparam logic [CFG_ADDR_W-1:0] REG_STEP_THRESHOLD = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_INTERVAL   = 2'd1;

  // about 0.8 g in q8.8, and 300 ms
  localparam logic [CFG_DATA_W-1:0] THRESH_RESET   = 16'd205;
  localparam logic [CFG_DATA_W-1:0] INTERVAL_RESET = 16'd300;

  typedef struct packed {
    logic                     req_type;
    logic signed [AXIS_W-1:0] accel_x;
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_z;
    logic [TIME_W-1:0]        now_ms;
  } in_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] step_count;
    logic [MAG_W-1:0]  avg_mag;
    logic              step_detected;
  } out_item_t;

endpackage

[hdl/asd_if.sv]
// channel interfaces for the step detector: samples, results and configuration
interface asd_in_if;
  logic               valid;
  logic               ready;
  asd_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface asd_out_if;
  logic               valid;
  logic               ready;
  asd_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface asd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [asd_pkg::CFG_ADDR_W-1:0]    addr;
  logic [asd_pkg::CFG_DATA_W-1:0]    wdata;
  modport source (output valid, output addr, output wdata, input ready);
  modport sink   (input valid, input addr, input wdata, output ready);
endinterface

[hdl/asd_mag.sv]
// bit-serial sum of squares, digit-serial square root and scaling to g
module asd_mag (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [asd_pkg::AXIS_W-1:0]   ax,
  input  logic [asd_pkg::AXIS_W-1:0]   ay,
  input  logic [asd_pkg::AXIS_W-1:0]   az,
  output logic                         done,
  output logic [asd_pkg::MAG_W-1:0]    mag_g
);
  import asd_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SQ    = 2'd1;
  localparam logic [1:0] ST_ROOT  = 2'd2;
  localparam logic [1:0] ST_SCALE = 2'd3;

  localparam int NUM_AXES   = 3;
  localparam int BIT_CW     = $clog2(AXIS_W);
  localparam int ROOT_STEPS = SQ_W / 2;
  localparam int ROOT_CW    = $clog2(ROOT_STEPS);
  localparam int REM_W      = ROOT_W + 2;
  localparam int PROD_W     = ROOT_W + RECIP_W;

  logic [1:0]          state_r;
  logic [BIT_CW-1:0]   bit_cnt_r;
  logic [1:0]          axis_cnt_r;
  logic [ROOT_CW-1:0]  root_cnt_r;
  logic [2*AXIS_W-1:0] pend_r;
  logic [SQ_W-1:0]     mcand_r;
  logic [AXIS_W-1:0]   mplier_r;
  logic [SQ_W-1:0]     acc_r;
  logic [SQ_W-1:0]     rad_r;
  logic [REM_W-1:0]    rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [MAG_W-1:0]    mag_g_r;
  logic                done_r;

  logic [SQ_W-1:0]     acc_nxt;
  logic [REM_W+1:0]    rem_sh;
  logic [REM_W+1:0]    trial;
  logic [REM_W+1:0]    diff;
  logic                fits;
  logic [PROD_W-1:0]   prod;

  // shift-and-add: one multiplier bit per cycle
  assign acc_nxt = acc_r + (mplier_r[0] ? mcand_r : '0);

  // restoring root: two radicand bits per cycle
  assign rem_sh = {rem_r, rad_r[SQ_W-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign fits   = (rem_sh >= trial);
  assign diff   = rem_sh - trial;

  assign prod = root_r * G_RECIP_Q16;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r <= ST_SQ;
          end
        end
        ST_SQ: begin
          if (bit_cnt_r == BIT_CW'(AXIS_W - 1) && axis_cnt_r == 2'(NUM_AXES - 1)) begin
            state_r <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (root_cnt_r == ROOT_CW'(ROOT_STEPS - 1)) begin
            state_r <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          state_r <= ST_IDLE;
          done_r  <= 1'b1;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        mcand_r    <= SQ_W'(ax);
        mplier_r   <= ax;
        pend_r     <= {az, ay};
        acc_r      <= '0;
        bit_cnt_r  <= '0;
        axis_cnt_r <= '0;
      end
      ST_SQ: begin
        acc_r     <= acc_nxt;
        bit_cnt_r <= bit_cnt_r + BIT_CW'(1);
        if (bit_cnt_r == BIT_CW'(AXIS_W - 1)) begin
          // next axis enters the multiplier
          mcand_r    <= SQ_W'(pend_r[AXIS_W-1:0]);
          mplier_r   <= pend_r[AXIS_W-1:0];
          pend_r     <= pend_r >> AXIS_W;
          axis_cnt_r <= axis_cnt_r + 2'd1;
          rad_r      <= acc_nxt;
          rem_r      <= '0;
          root_r     <= '0;
          root_cnt_r <= '0;
        end else begin
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
        end
      end
      ST_ROOT: begin
        rem_r      <= fits ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
        root_r     <= {root_r[ROOT_W-2:0], fits};
        rad_r      <= rad_r << 2;
        root_cnt_r <= root_cnt_r + ROOT_CW'(1);
      end
      ST_SCALE: begin
        mag_g_r <= MAG_W'(prod >> 16);
      end
      default: begin
        acc_r <= acc_r;
      end
    endcase
  end

  assign done  = done_r;
  assign mag_g = mag_g_r;

endmodule

[hdl/asd_div.sv]
// bit-serial restoring divider for the window average
module asd_div #(
  parameter int SUM_W = 19,
  parameter int CNT_W = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quot
);

  localparam int STEP_CW = $clog2(SUM_W);

  logic               busy_r;
  logic               done_r;
  logic [STEP_CW-1:0] step_r;
  logic [SUM_W-1:0]   dvd_r;
  logic [CNT_W-1:0]   dsr_r;
  logic [CNT_W-1:0]   rem_r;

  logic [CNT_W:0]     rem_sh;
  logic [CNT_W:0]     diff;
  logic               fits;

  assign rem_sh = {rem_r, dvd_r[SUM_W-1]};
  assign fits   = (rem_sh >= {1'b0, dsr_r});
  assign diff   = rem_sh - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == STEP_CW'(SUM_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // quotient bits shift in where dividend bits leave
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r  <= dividend;
      dsr_r  <= divisor;
      rem_r  <= '0;
      step_r <= '0;
    end else if (busy_r) begin
      dvd_r  <= {dvd_r[SUM_W-2:0], fits};
      rem_r  <= fits ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      step_r <= step_r + STEP_CW'(1);
    end
  end

  assign done = done_r;
  assign quot = dvd_r;

endmodule

[hdl/accel_step_detector_unit.sv]
// top level of the accelerometer step detector
//
//  channel  direction  handshake      payload
//  in_ch    sink       valid / ready  req_type, accel_x/y/z (q8.8 m/s2), now_ms
//  out_ch   source     valid / ready  step_count, avg_mag (q8.8 g), step_detected
//  cfg_ch   sink       valid / ready  addr (0 threshold, 1 min interval), wdata
//
// a sample goes through the squaring, root and scaling of asd_mag, ST_UPD, the divider
// and ST_DONE into the output register, and in_ch is ready again in the cycle that its
// result becomes valid; the bit-serial squaring and root dominate, the divider works
// one sum bit per cycle. a clear request goes by ST_DONE into the output register.
// one item is worked on at a time; the next is accepted while a result waits.
// rst_n is synchronous and active low; it restores the window, counters and registers.
// cfg_ch is always ready; a stall on out_ch holds the result register, and a second
// finished item then waits in its staging register with in_ch held off.
module accel_step_detector_unit #(
  parameter int WINDOW = 5
) (
  input logic       clk,
  input logic       rst_n,
  asd_in_if.sink    in_ch,
  asd_out_if.source out_ch,
  asd_cfg_if.sink   cfg_ch
);
  import asd_pkg::*;

  localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SUM_W = MAG_W + $clog2(WINDOW);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MAG  = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  function automatic logic [AXIS_W-1:0] abs_axis(input logic [AXIS_W-1:0] v);
    return v[AXIS_W-1] ? (~v + AXIS_W'(1)) : v;
  endfunction

  // control and detector state
  logic [2:0]            state_r;
  logic [CFG_DATA_W-1:0] thr_r;
  logic [CFG_DATA_W-1:0] intv_r;
  logic [MAG_W-1:0]      win_r [WINDOW];
  logic [POS_W-1:0]      pos_r;
  logic                  full_r;
  logic [SUM_W-1:0]      sum_r;
  logic                  peak_r;
  logic [TIME_W-1:0]     last_step_r;
  logic [TIME_W-1:0]     steps_r;
  logic [MAG_W-1:0]      last_avg_r;
  logic                  out_valid_r;

  // payload
  logic [TIME_W-1:0]     now_ms_r;
  out_item_t             res_r;
  out_item_t             out_data_r;

  logic                  in_acc;
  logic                  is_clear;
  logic                  mag_start;
  logic                  mag_done;
  logic [MAG_W-1:0]      mag_g;
  logic                  div_done;
  logic [SUM_W-1:0]      quot;

  logic [CNT_W-1:0]      pos_inc;
  logic                  wrap;
  logic [POS_W-1:0]      pos_nxt;
  logic                  full_nxt;
  logic [CNT_W-1:0]      count_nxt;
  logic [SUM_W-1:0]      sum_nxt;

  logic [MAG_W-1:0]      avg;
  logic                  above;
  logic [TIME_W-1:0]     gap;
  logic                  fire;
  logic [TIME_W-1:0]     steps_nxt;
  logic                  out_free;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign is_clear  = (in_ch.data.req_type == REQ_CLEAR);
  assign mag_start = in_acc && !is_clear;
  assign out_free  = !out_valid_r || out_ch.ready;

  asd_mag u_mag (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mag_start),
    .ax    (abs_axis(in_ch.data.accel_x)),
    .ay    (abs_axis(in_ch.data.accel_y)),
    .az    (abs_axis(in_ch.data.accel_z)),
    .done  (mag_done),
    .mag_g (mag_g)
  );

  // circular window: replace the oldest magnitude, keep the running sum
  assign pos_inc   = CNT_W'(pos_r) + CNT_W'(1);
  assign wrap      = (pos_inc == CNT_W'(WINDOW));
  assign pos_nxt   = wrap ? '0 : pos_inc[POS_W-1:0];
  assign full_nxt  = full_r || wrap;
  // before the window has filled the average is over the entries held so far
  assign count_nxt = full_nxt ? CNT_W'(WINDOW) : pos_inc;
  assign sum_nxt   = sum_r - SUM_W'(win_r[pos_r]) + SUM_W'(mag_g);

  asd_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_UPD),
    .dividend (sum_nxt),
    .divisor  (count_nxt),
    .done     (div_done),
    .quot     (quot)
  );

  // saturate the average to 16 bits
  assign avg = (quot > SUM_W'({MAG_W{1'b1}})) ? {MAG_W{1'b1}} : quot[MAG_W-1:0];

  // step when above threshold, armed and the wrapping gap exceeds the interval
  assign above     = (avg > thr_r);
  assign gap       = now_ms_r - last_step_r;
  assign fire      = above && !peak_r && (gap > TIME_W'(intv_r));
  assign steps_nxt = steps_r + TIME_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      thr_r       <= THRESH_RESET;
      intv_r      <= INTERVAL_RESET;
      pos_r       <= '0;
      full_r      <= 1'b0;
      sum_r       <= '0;
      peak_r      <= 1'b0;
      last_step_r <= '0;
      steps_r     <= '0;
      last_avg_r  <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < WINDOW; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      // register writes
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.addr)
          REG_STEP_THRESHOLD: thr_r  <= cfg_ch.wdata;
          REG_MIN_INTERVAL:   intv_r <= cfg_ch.wdata;
          default: begin
            thr_r <= thr_r;
          end
        endcase
      end

      // a new result may replace the one leaving in the same cycle
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (is_clear) begin
              // clear touches only the step count
              steps_r <= '0;
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_MAG;
            end
          end
        end
        ST_MAG: begin
          if (mag_done) begin
            state_r <= ST_UPD;
          end
        end
        ST_UPD: begin
          win_r[pos_r] <= mag_g;
          sum_r        <= sum_nxt;
          pos_r        <= pos_nxt;
          full_r       <= full_nxt;
          state_r      <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            if (fire) begin
              steps_r     <= steps_nxt;
              last_step_r <= now_ms_r;
              peak_r      <= 1'b1;
            end else if (!above) begin
              // re-arm once the average drops back
              peak_r <= 1'b0;
            end
            last_avg_r <= avg;
            state_r    <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // result staging and output register
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_acc) begin
      now_ms_r            <= in_ch.data.now_ms;
      res_r.step_count    <= '0;
      res_r.avg_mag       <= last_avg_r;
      res_r.step_detected <= 1'b0;
    end else if (state_r == ST_DIV && div_done) begin
      res_r.step_count    <= fire ? steps_nxt : steps_r;
      res_r.avg_mag       <= avg;
      res_r.step_detected <= fire;
    end
    if (state_r == ST_DONE && out_free) begin
      out_data_r <= res_r;
    end
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

[hdl/asd_chk.sv]
// port-level checker for the step detector, bound to the top level
module asd_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input asd_pkg::out_item_t out_data
);

  logic [1:0] pend_r;
  logic [1:0] pend_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // transactions accepted whose result has not yet left
  always_comb begin
    pend_nxt = pend_r + 2'(in_acc) - 2'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("input taken while previous item still in work");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != 2'd0) && (pend_r <= 2'd2))
    else $error("result without an outstanding transaction");

  a_step_above_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.step_detected |-> out_data.avg_mag != '0)
    else $error("step flagged with zero average");

endmodule

bind accel_step_detector_unit asd_chk u_asd_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

[bench/accel_step_detector_unit_tb.sv]
// self-checking testbench for the accelerometer step detector top level
module accel_step_detector_unit_tb;
  import asd_pkg::*;

  // window length handed to the block, and the sample latency
  localparam int WIN_LEN         = 5;
  localparam int RESULT_LATENCY  = 88;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int CYCLE_LIMIT     = 1_500_000;
  localparam int PHASE_ITEMS     = 600;

  // register indexes with no register behind them
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_A = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_B = 2'd3;
  localparam logic REQ_SAMPLE = 1'b0;

  logic clk;
  logic rst_n;

  asd_in_if  in_ch ();
  asd_out_if out_ch ();
  asd_cfg_if cfg_ch ();

  accel_step_detector_unit #(
    .WINDOW (WIN_LEN)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // ---------------------------------------------------------------------------
  // pedometer state mirrored in the bench
  // ---------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] thr_q;         // step threshold, q8.8 g
  logic [CFG_DATA_W-1:0] gap_ms;        // spacing that a counted step must exceed
  logic [MAG_W-1:0]      win_mag [WIN_LEN];
  int unsigned           win_pos;
  bit                    win_full;
  logic [18:0]           window_sum;
  bit                    peak_held;     // detector disarmed until the average drops
  logic [TIME_W-1:0]     last_step_at;
  logic [TIME_W-1:0]     steps_seen;
  logic [MAG_W-1:0]      last_avg;

  // results still owed by the block, oldest first
  out_item_t awaited_reports [$];

  int  in_gap_pct;                      // chance in a hundred that the sender idles
  int  out_stall_pct;                   // chance in a hundred that the receiver stalls
  int  items_sent;
  int  fail_count;
  int  cycle_count;
  bit  rx_held;
  logic [TIME_W-1:0] tick_ms;           // running timestamp for walking sequences
  event hold_off_ev;

  // ---------------------------------------------------------------------------
  // arithmetic of the detector
  // ---------------------------------------------------------------------------
  function automatic logic [AXIS_W-1:0] axis_abs(logic signed [AXIS_W-1:0] a);
    logic [AXIS_W-1:0] u;
    u = a;
    // -32768 folds to 32768, which still fits 16 unsigned bits
    return u[AXIS_W-1] ? (~u + 16'd1) : u;
  endfunction

  function automatic logic [ROOT_W-1:0] floor_root(logic [SQ_W-1:0] v);
    logic [ROOT_W-1:0] r;
    logic [ROOT_W-1:0] trial;
    r = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      trial = r | (16'd1 << b);
      if (32'(trial) * 32'(trial) <= v) r = trial;
    end
    return r;
  endfunction

  function automatic void reset_pedometer();
    thr_q        = THRESH_RESET;
    gap_ms       = INTERVAL_RESET;
    for (int i = 0; i < WIN_LEN; i++) win_mag[i] = '0;
    win_pos      = 0;
    win_full     = 1'b0;
    window_sum   = '0;
    peak_held    = 1'b0;
    last_step_at = '0;
    steps_seen   = '0;
    last_avg     = '0;
  endfunction

  // advances the mirrored state by one accepted transaction, gives its result
  function automatic out_item_t predict_result(in_item_t it);
    out_item_t         res;
    logic [AXIS_W-1:0] ax, ay, az;
    logic [SQ_W-1:0]   sq;
    logic [31:0]       scaled;
    logic [MAG_W-1:0]  mag_g;
    logic [MAG_W-1:0]  avg;
    logic [18:0]       avg_wide;
    logic [TIME_W-1:0] elapsed;
    int unsigned       held;
    res = '0;
    if (it.req_type == REQ_CLEAR) begin
      // clear touches the step total only
      steps_seen  = '0;
      res.avg_mag = last_avg;
      return res;
    end
    ax     = axis_abs(it.accel_x);
    ay     = axis_abs(it.accel_y);
    az     = axis_abs(it.accel_z);
    sq     = 32'(ax) * 32'(ax) + 32'(ay) * 32'(ay) + 32'(az) * 32'(az);
    scaled = 32'(floor_root(sq)) * 32'(G_RECIP_Q16);
    mag_g  = scaled[31:16];

    window_sum       = window_sum - 19'(win_mag[win_pos]) + 19'(mag_g);
    win_mag[win_pos] = mag_g;
    if (win_pos == WIN_LEN - 1) begin
      win_pos  = 0;
      win_full = 1'b1;
    end else begin
      win_pos++;
    end
    held = win_full ? WIN_LEN : win_pos;
    if (held == 0) held = WIN_LEN;
    avg_wide = window_sum / 19'(held);
    avg      = (avg_wide > 19'h0FFFF) ? 16'hFFFF : avg_wide[15:0];

    // interval measured modulo 2^32 so a wrapping clock still works
    elapsed = it.now_ms - last_step_at;
    if (avg > thr_q) begin
      if (!peak_held && elapsed > 32'(gap_ms)) begin
        steps_seen        = steps_seen + 32'd1;
        last_step_at      = it.now_ms;
        peak_held         = 1'b1;
        res.step_detected = 1'b1;
      end
    end else begin
      peak_held = 1'b0;
    end
    last_avg       = avg;
    res.step_count = steps_seen;
    res.avg_mag    = avg;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // clock, watchdog, receiver
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // long receiver hold-off, counted here so the sender keeps running meanwhile
  initial begin : hold_off_timer
    rx_held = 1'b0;
    forever begin
      @(hold_off_ev);
      rx_held <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clk);
      rx_held <= 1'b0;
    end
  end

  initial begin : result_sink
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= rst_n && !rx_held && ($urandom_range(99) >= out_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // result checking, one transaction at a time against the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic report_field(string field, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_reports.size() == 0) begin
        $display("%0t: unexpected result expected none actual %h", $time, out_ch.data);
        fail_count++;
      end else begin
        want = awaited_reports.pop_front();
        report_field("step_count", want.step_count, out_ch.data.step_count);
        report_field("avg_mag", want.avg_mag, out_ch.data.avg_mag);
        report_field("step_detected", want.step_detected, out_ch.data.step_detected);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // shared driving tasks, all entered and left on a rising edge
  // ---------------------------------------------------------------------------
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < in_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    awaited_reports.push_back(predict_result(it));
    items_sent++;
  endtask

  // sender pause until every owed result is back, then a short margin
  task automatic wait_for_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (awaited_reports.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    wait_for_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= idx;
    cfg_ch.wdata <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_STEP_THRESHOLD: thr_q  = val;
      REG_MIN_INTERVAL:   gap_ms = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic in_item_t sample_of(logic signed [AXIS_W-1:0] x,
                                         logic signed [AXIS_W-1:0] y,
                                         logic signed [AXIS_W-1:0] z,
                                         logic [TIME_W-1:0] t);
    in_item_t it;
    it.req_type = REQ_SAMPLE;
    it.accel_x  = x;
    it.accel_y  = y;
    it.accel_z  = z;
    it.now_ms   = t;
    return it;
  endfunction

  function automatic in_item_t clear_request();
    in_item_t it;
    // axes and timestamp are junk, the block must ignore them
    it          = sample_of(16'($urandom), 16'($urandom), 16'($urandom), $urandom);
    it.req_type = REQ_CLEAR;
    return it;
  endfunction

  function automatic logic signed [AXIS_W-1:0] axis_near(int centre, int spread);
    int v;
    v = centre - spread + int'($urandom_range(2 * spread));
    if ($urandom_range(1) == 1) v = -v;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic logic [TIME_W-1:0] next_tick();
    if ($urandom_range(39) == 0) tick_ms = $urandom;
    else tick_ms = tick_ms + $urandom_range(5, 350);
    return tick_ms;
  endfunction

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------

  // threshold 205 and interval 300 straight out of reset
  task automatic test_default_registers();
    send_item(sample_of(0, 0, 2509, 32'd300));   // interval exactly met, no step
    send_item(sample_of(0, 0, 2509, 32'd301));   // first counted step
    send_item(sample_of(0, -2509, 0, 32'd400));  // still above, detector disarmed
  endtask

  task automatic test_clear_request();
    send_item(clear_request());
    send_item(sample_of(0, 0, 0, 32'd500));
  endtask

  task automatic test_axis_extremes();
    send_item(sample_of(-32768, -32768, -32768, 32'd1000));
    send_item(sample_of(32767, 32767, 32767, 32'd1001));
    send_item(sample_of(-32768, 0, 0, 32'h7FFF_FFFF));
    send_item(sample_of(0, 32767, -1, 32'h8000_0000));
    send_item(sample_of(0, 0, 0, 32'hFFFF_FFFF));
  endtask

  // threshold flips between its extremes to re-arm and trigger on demand
  task automatic test_timestamp_wrap();
    write_register(REG_STEP_THRESHOLD, 16'hFFFF);
    send_item(sample_of(100, 0, 0, 32'hFFFF_FF00));
    write_register(REG_STEP_THRESHOLD, 16'h0000);
    write_register(REG_MIN_INTERVAL, 16'd100);
    send_item(sample_of(0, 0, 2509, 32'hFFFF_FFF0));
    write_register(REG_STEP_THRESHOLD, 16'hFFFF);
    send_item(sample_of(0, 0, 2509, 32'hFFFF_FFF8));
    write_register(REG_STEP_THRESHOLD, 16'h0000);
    send_item(sample_of(0, 2509, 0, 32'h0000_0040));  // 80 ms across the wrap
    send_item(sample_of(0, 2509, 0, 32'h0000_0060));  // 112 ms across the wrap
  endtask

  task automatic test_interval_extremes();
    write_register(REG_STEP_THRESHOLD, 16'hFFFF);
    send_item(sample_of(0, 0, 2509, 32'h0000_1000));
    write_register(REG_STEP_THRESHOLD, 16'h0000);
    write_register(REG_MIN_INTERVAL, 16'hFFFF);
    send_item(sample_of(0, 0, 2509, 32'h0001_005F));  // exactly 65535 ms
    send_item(sample_of(0, 0, 2509, 32'h0001_0060));
    write_register(REG_STEP_THRESHOLD, 16'hFFFF);
    send_item(sample_of(0, 0, 2509, 32'h0001_0060));
    write_register(REG_STEP_THRESHOLD, 16'h0000);
    write_register(REG_MIN_INTERVAL, 16'h0000);
    send_item(sample_of(0, 0, 2509, 32'h0001_0060));  // zero elapsed, zero interval
    send_item(sample_of(0, 0, 2509, 32'h0001_0061));
  endtask

  task automatic test_unused_register_index();
    write_register(REG_UNUSED_A, 16'($urandom));
    write_register(REG_UNUSED_B, 16'($urandom));
    write_register(REG_STEP_THRESHOLD, THRESH_RESET);
    write_register(REG_MIN_INTERVAL, INTERVAL_RESET);
    send_item(sample_of(0, 0, 0, 32'h0002_0000));
    send_item(clear_request());
  endtask

  // receiver stalls for a long stretch while samples keep coming
  task automatic test_output_backpressure();
    int saved_in, saved_out;
    saved_in      = in_gap_pct;
    saved_out     = out_stall_pct;
    wait_for_idle();
    in_gap_pct    = 0;
    out_stall_pct = 0;
    -> hold_off_ev;
    repeat (12) send_item(sample_of(axis_near(3000, 2000), axis_near(0, 500),
                                    axis_near(0, 500), next_tick()));
    wait_for_idle();
    in_gap_pct    = saved_in;
    out_stall_pct = saved_out;
  endtask

  // ---------------------------------------------------------------------------
  // random walking sequences with noise and clears mixed in
  // ---------------------------------------------------------------------------
  task automatic send_walk_burst();
    int level, n_up, n_down, lead;
    // stride peaks spread around the threshold, which is about level / 10 in g
    level  = int'(thr_q) * $urandom_range(4, 25);
    if (level > 32000) level = 32000;
    if (level < 64) level = 64;
    n_up   = $urandom_range(1, 6);
    n_down = $urandom_range(1, 6);
    repeat (n_up) begin
      lead = $urandom_range(2);
      case (lead)
        0: send_item(sample_of(axis_near(level, level / 8), axis_near(0, 300),
                               axis_near(0, 300), next_tick()));
        1: send_item(sample_of(axis_near(0, 300), axis_near(level, level / 8),
                               axis_near(0, 300), next_tick()));
        default: send_item(sample_of(axis_near(0, 300), axis_near(0, 300),
                                     axis_near(level, level / 8), next_tick()));
      endcase
    end
    repeat (n_down)
      send_item(sample_of(axis_near(0, level / 4), axis_near(0, level / 4),
                          axis_near(0, level / 4), next_tick()));
  endtask

  task automatic test_random_walking(int gap_pct, int stall_pct);
    int start, pick;
    write_register(REG_STEP_THRESHOLD, 16'($urandom_range(100, 1200)));
    write_register(REG_MIN_INTERVAL, 16'($urandom_range(0, 500)));
    in_gap_pct    = gap_pct;
    out_stall_pct = stall_pct;
    start         = items_sent;
    while (items_sent - start < PHASE_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        send_walk_burst();
      end else if (pick < 92) begin
        send_item(sample_of(16'($urandom), 16'($urandom), 16'($urandom), $urandom));
      end else begin
        send_item(clear_request());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.addr   = '0;
    cfg_ch.wdata  = '0;
    in_gap_pct    = 32;
    out_stall_pct = 79;
    items_sent    = 0;
    fail_count    = 0;
    tick_ms       = 32'hFFFF_F000;  // walking clock crosses the wrap early on
    reset_pedometer();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_default_registers();
    test_clear_request();
    test_axis_extremes();
    test_timestamp_wrap();
    test_interval_extremes();
    test_unused_register_index();
    test_output_backpressure();
    test_random_walking(32, 79);
    test_random_walking(79, 32);
    test_random_walking(0, 0);

    wait_for_idle();
    repeat (RESULT_LATENCY + 20) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
